// ===== rtl/tlld_pkg.sv =====
// Shared definitions for the type/length line deframer.
// Character constants, marker words, result codes and the line-end summary struct.
// No dependencies.
package tlld_pkg;

   localparam int TYPE_BITS_DEF   = 32;
   localparam int LENGTH_BITS_DEF = 31;

   // Result queue: four entries, so a line end with two reports always fits.
   localparam int Q_DEPTH    = 4;
   localparam int Q_IDX_BITS = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // "Type" and ";Len" as they sit in the four-byte history, newest byte low.
   localparam logic [31:0] WORD_TYPE = 32'h5479_7065;
   localparam logic [31:0] WORD_LEN  = 32'h3B4C_656E;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [2:0] CODE_NONE     = 3'd0;
   localparam logic [2:0] CODE_NO_TYPE  = 3'd0;
   localparam logic [2:0] CODE_NO_LEN   = 3'd1;
   localparam logic [2:0] CODE_BAD_TYPE = 3'd2;
   localparam logic [2:0] CODE_BAD_LEN  = 3'd3;
   localparam logic [2:0] CODE_EARLY    = 3'd4;

   // Outcome of a header line, valid in the cycle the CR LF completes.
   typedef struct packed {
      logic       done;   // line ended this transaction
      logic       early;  // bytes came before the marker
      logic       fail;   // an error report follows
      logic [2:0] code;   // error code when fail
   } line_type;

endpackage

// ===== rtl/tlld_header.sv =====
// Header line parser: CR LF detection, marker search and decimal field accumulation.
// Depends on tlld_pkg.
module tlld_header #(
   parameter int TYPE_BITS   = tlld_pkg::TYPE_BITS_DEF,
   parameter int LENGTH_BITS = tlld_pkg::LENGTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             in_byte,
   output tlld_pkg::line_type     line,
   output logic [TYPE_BITS-1:0]   hdr_type_val,
   output logic [LENGTH_BITS-1:0] hdr_length
);

   typedef enum logic [2:0] {
      PH_SEEK = 3'b001,
      PH_TYPE = 3'b010,
      PH_LEN  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [31:0]            recent;
      phase_type              phase;
      logic [TYPE_BITS-2:0]   tacc;
      logic [LENGTH_BITS-1:0] lacc;
      logic                   tbad;
      logic                   lbad;
      logic                   thas;
      logic                   lhas;
      logic                   lhb;
      logic [2:0]             run;
   } hdr_type;

   localparam hdr_type HDR_CLEAR = '{
      recent: 32'd0, phase: PH_SEEK, tacc: '0, lacc: '0, tbad: 1'b0, lbad: 1'b0,
      thas: 1'b0, lhas: 1'b0, lhb: 1'b0, run: 3'd0
   };

   // One line byte through the marker matcher and the number accumulators.
   // Type digits trail by four bytes so that ";Len" never reaches the type text.
   function automatic hdr_type feed(input hdr_type s, input logic [7:0] x);
      hdr_type                n;
      logic [7:0]             c;
      logic [3:0]             d;
      logic [TYPE_BITS+2:0]   tprod;
      logic [LENGTH_BITS+3:0] lprod;
      logic                   tmark;
      logic                   lmark;
      begin
         n      = s;
         c      = s.recent[31:24];
         d      = 4'd0;
         tprod  = '0;
         lprod  = '0;
         tmark  = (s.recent == tlld_pkg::WORD_TYPE) && (x == tlld_pkg::CHAR_COLON);
         lmark  = (s.recent == tlld_pkg::WORD_LEN) && (x == tlld_pkg::CHAR_COLON);
         n.recent = {s.recent[23:0], x};
         if (tmark) begin
            n.lhb   = (s.phase != PH_SEEK) || (s.run > 3'd4);
            n.phase = PH_TYPE;
            n.tacc  = '0;
            n.lacc  = '0;
            n.tbad  = 1'b0;
            n.lbad  = 1'b0;
            n.thas  = 1'b0;
            n.lhas  = 1'b0;
            n.run   = 3'd0;
         end else begin
            if (s.phase == PH_TYPE && lmark) begin
               n.phase = PH_LEN;
            end else if (s.phase == PH_TYPE) begin
               if (s.run >= 3'd4) begin
                  if (c < tlld_pkg::CHAR_ZERO || c > tlld_pkg::CHAR_NINE) begin
                     n.tbad = 1'b1;
                  end else begin
                     d      = 4'(c - tlld_pkg::CHAR_ZERO);
                     n.thas = 1'b1;
                     tprod  = ({4'b0, s.tacc} << 3) + ({4'b0, s.tacc} << 1)
                              + (TYPE_BITS+3)'(d);
                     if (!s.tbad) begin
                        if (tprod[TYPE_BITS+2:TYPE_BITS-1] != '0) begin
                           n.tbad = 1'b1;
                        end else begin
                           n.tacc = tprod[TYPE_BITS-2:0];
                        end
                     end
                  end
               end
            end else if (s.phase == PH_LEN) begin
               if (x < tlld_pkg::CHAR_ZERO || x > tlld_pkg::CHAR_NINE) begin
                  n.lbad = 1'b1;
               end else begin
                  d      = 4'(x - tlld_pkg::CHAR_ZERO);
                  n.lhas = 1'b1;
                  lprod  = ({4'b0, s.lacc} << 3) + ({4'b0, s.lacc} << 1)
                           + (LENGTH_BITS+4)'(d);
                  if (!s.lbad) begin
                     if (lprod[LENGTH_BITS+3:LENGTH_BITS] != '0) begin
                        n.lbad = 1'b1;
                     end else begin
                        n.lacc = lprod[LENGTH_BITS-1:0];
                     end
                  end
               end
            end
            if (s.run != 3'd7) begin
               n.run = s.run + 3'd1;
            end
         end
         return n;
      end
   endfunction

   hdr_type hdr_ff, hdr_in;
   logic    cr_ff, cr_in;
   hdr_type fed_cr, base, fed_byte;
   logic    line_end;

   assign line_end = step && cr_ff && (in_byte == tlld_pkg::CHAR_LF);

   always_comb begin
      // A held CR that is not part of CR LF is an ordinary line byte.
      fed_cr   = feed(hdr_ff, tlld_pkg::CHAR_CR);
      base     = cr_ff ? fed_cr : hdr_ff;
      fed_byte = feed(base, in_byte);
      hdr_in   = hdr_ff;
      cr_in    = cr_ff;
      if (step) begin
         if (line_end) begin
            hdr_in = HDR_CLEAR;
            cr_in  = 1'b0;
         end else if (in_byte == tlld_pkg::CHAR_CR) begin
            hdr_in = base;
            cr_in  = 1'b1;
         end else begin
            hdr_in = fed_byte;
            cr_in  = 1'b0;
         end
      end
   end

   always_comb begin
      line.done  = line_end;
      line.early = 1'b0;
      line.fail  = 1'b1;
      line.code  = tlld_pkg::CODE_NO_TYPE;
      if (hdr_ff.phase != PH_SEEK) begin
         line.early = hdr_ff.lhb;
         priority if (hdr_ff.phase == PH_TYPE) begin
            line.code = tlld_pkg::CODE_NO_LEN;
         end else if (hdr_ff.tbad || !hdr_ff.thas) begin
            line.code = tlld_pkg::CODE_BAD_TYPE;
         end else if (hdr_ff.lbad || !hdr_ff.lhas) begin
            line.code = tlld_pkg::CODE_BAD_LEN;
         end else begin
            line.fail = 1'b0;
         end
      end
   end

   assign hdr_type_val = {1'b0, hdr_ff.tacc};
   assign hdr_length   = hdr_ff.lacc;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= HDR_CLEAR;
         cr_ff  <= 1'b0;
      end else begin
         hdr_ff <= hdr_in;
         cr_ff  <= cr_in;
      end
   end

endmodule

// ===== rtl/type_length_line_deframer.sv =====
// Top level of the type/length line deframer: payload counter and result queue.
// Depends on tlld_pkg and tlld_header.
//
// The deframer accepts one byte per clock cycle, every cycle, as long as its result
// queue has room for two entries. Header lines ending in CR LF are parsed on the fly;
// a payload byte produces one result transaction, written into the queue as it is accepted,
// and a line end produces zero, one or two status transactions. Results wait in a
// four-entry queue, so req_ready drops only when three or more results are pending
// because the consumer is stalling.
module type_length_line_deframer #(
   parameter int TYPE_BITS   = tlld_pkg::TYPE_BITS_DEF,
   parameter int LENGTH_BITS = tlld_pkg::LENGTH_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_in_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_out_kind,
   output logic [7:0]                  rsp_payload_byte,
   output logic signed [TYPE_BITS-1:0] rsp_message_type,
   output logic                        rsp_last_of_message,
   output logic [2:0]                  rsp_status_code
);

   typedef struct packed {
      logic                 kind;
      logic [7:0]           data;
      logic [TYPE_BITS-1:0] mtype;
      logic                 last;
      logic [2:0]           code;
   } result_type;

   logic                   in_payload_ff, in_payload_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;
   logic [TYPE_BITS-1:0]   cur_type_ff, cur_type_in;

   result_type                    queue_ff [tlld_pkg::Q_DEPTH];
   logic [tlld_pkg::Q_IDX_BITS-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [tlld_pkg::Q_CNT_BITS-1:0] count_ff, count_in;

   logic                   accept;
   logic                   hdr_step;
   tlld_pkg::line_type     line;
   logic [TYPE_BITS-1:0]   hdr_type_val;
   logic [LENGTH_BITS-1:0] hdr_length;
   logic [1:0]             push_n;
   result_type             ent0, ent1;
   logic                   pop;

   assign req_ready = count_ff <= tlld_pkg::Q_CNT_BITS'(tlld_pkg::Q_DEPTH - 2);
   assign accept    = req_valid && req_ready;
   assign hdr_step  = accept && !in_payload_ff;
   assign pop       = rsp_valid && rsp_ready;

   tlld_header #(
      .TYPE_BITS   (TYPE_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_header (
      .clock        (clock),
      .reset        (reset),
      .step         (hdr_step),
      .in_byte      (req_in_byte),
      .line         (line),
      .hdr_type_val (hdr_type_val),
      .hdr_length   (hdr_length)
   );

   always_comb begin
      in_payload_in = in_payload_ff;
      remain_in     = remain_ff;
      cur_type_in   = cur_type_ff;
      push_n        = 2'd0;
      ent0          = '{kind: tlld_pkg::KIND_STATUS, data: 8'd0, mtype: '0, last: 1'b0,
                        code: tlld_pkg::CODE_NONE};
      ent1          = ent0;
      if (accept && in_payload_ff) begin
         push_n        = 2'd1;
         ent0.kind     = tlld_pkg::KIND_PAYLOAD;
         ent0.data     = req_in_byte;
         ent0.mtype    = cur_type_ff;
         ent0.last     = (remain_ff == LENGTH_BITS'(1));
         remain_in     = remain_ff - LENGTH_BITS'(1);
         in_payload_in = (remain_ff != LENGTH_BITS'(1));
      end else if (line.done) begin
         // Early-data report goes out ahead of the error report.
         push_n    = {1'b0, line.early} + {1'b0, line.fail};
         ent0.code = line.early ? tlld_pkg::CODE_EARLY : line.code;
         ent1.code = line.code;
         if (!line.fail) begin
            cur_type_in   = hdr_type_val;
            remain_in     = hdr_length;
            in_payload_in = (hdr_length != '0);
         end
      end
   end

   assign tail_in  = tail_ff + tlld_pkg::Q_IDX_BITS'(push_n);
   assign head_in  = pop ? head_ff + tlld_pkg::Q_IDX_BITS'(1) : head_ff;
   assign count_in = count_ff + tlld_pkg::Q_CNT_BITS'(push_n)
                     - tlld_pkg::Q_CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[tail_ff] <= ent0;
      end
      if (push_n == 2'd2) begin
         queue_ff[tail_ff + tlld_pkg::Q_IDX_BITS'(1)] <= ent1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         remain_ff     <= '0;
         cur_type_ff   <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
      end else begin
         in_payload_ff <= in_payload_in;
         remain_ff     <= remain_in;
         cur_type_ff   <= cur_type_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
      end
   end

   assign rsp_valid           = count_ff != '0;
   assign rsp_out_kind        = queue_ff[head_ff].kind;
   assign rsp_payload_byte    = queue_ff[head_ff].data;
   assign rsp_message_type    = queue_ff[head_ff].mtype;
   assign rsp_last_of_message = queue_ff[head_ff].last;
   assign rsp_status_code     = queue_ff[head_ff].code;

endmodule

// ===== test/tb_type_length_line_deframer.sv =====
// Self-checking testbench for type_length_line_deframer: a table of header lines, then
// random framed messages with noise, checked against a behavioral deframer.
// Depends on tlld_pkg and the RTL of the deframer.
module tb_type_length_line_deframer;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1550;
   localparam int QUIET_ITEMS  = 300;
   localparam int N_ROWS       = 16;
   localparam logic [63:0] TYPE_MAX = (64'd1 << (tlld_pkg::TYPE_BITS_DEF - 1)) - 64'd1;
   localparam logic [63:0] LEN_MAX  = (64'd1 << tlld_pkg::LENGTH_BITS_DEF) - 64'd1;

   typedef enum logic [1:0] {PH_SEEK, PH_TYPE, PH_LEN} phase_type;
   typedef enum int {FLAW_NOISE, FLAW_PREFIX, FLAW_NO_LEN, FLAW_TYPE_CHAR, FLAW_LEN_CHAR,
                     FLAW_OVERFLOW, FLAW_REMARK, FLAW_LONE} flaw_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data;
      logic [31:0] mtype;
      logic        last;
      logic [2:0]  code;
   } deframed_type;

   typedef struct packed {
      logic [1:0] count;
      logic [2:0] first;
      logic [2:0] second;
   } typed_line_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_typed = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic        rsp_out_kind;
   logic [7:0]  rsp_payload_byte;
   logic signed [31:0] rsp_message_type;
   logic        rsp_last_of_message;
   logic [2:0]  rsp_status_code;

   int          errors = 0;
   int          cycle_count = 0;
   int          bytes_sent = 0;
   int          stall_left = 0;
   logic        idle_on = 1'b1;

   deframed_type   pending_results[$];
   deframed_type   step_results[$];
   typed_line_type typed_lines[$];
   logic [7:0]     frame_q[$];

   // behavioral deframer state
   logic        pay_mode;
   logic [30:0] pay_left;
   logic [31:0] cur_type;
   logic [31:0] hist;
   phase_type   phase;
   logic [31:0] type_acc;
   logic [30:0] len_acc;
   logic        type_bad, len_bad, type_dig, len_dig, early, cr_held;
   logic [2:0]  run;
   logic        line_closed;

   string row_text [N_ROWS] = '{
      "\r\n", "Type:5\r\n", "Type:;Len:3\r\n", "Type:12;Len:\r\n",
      "xType:1;Len:0\r\n", "Type:2147483647;Len:2\r\n", "Type:2147483648;Len:1\r\n",
      "Type:1;Len:2147483648\r\n", "Type:+1;Len:1\r\n", "Type:3;Len: 1\r\n",
      "Type:9;Type:4;Len:2\r\n\r\n", "a\rb\nType:0;Len:3\r\n", "\r\r\n",
      "zz;Len:4\r\n", "qType:x\r\n", "Type:7;Len:99999999999\r\n"};
   // -1: checked by the behavioral deframer, else number of status reports typed in
   int row_reports [N_ROWS] = '{1, 1, 1, 1, 1, -1, 1, 1, 1, 1, -1, -1, 1, 1, 2, 1};
   logic [2:0] row_first [N_ROWS] = '{
      tlld_pkg::CODE_NO_TYPE, tlld_pkg::CODE_NO_LEN, tlld_pkg::CODE_BAD_TYPE,
      tlld_pkg::CODE_BAD_LEN, tlld_pkg::CODE_EARLY, tlld_pkg::CODE_NONE,
      tlld_pkg::CODE_BAD_TYPE, tlld_pkg::CODE_BAD_LEN, tlld_pkg::CODE_BAD_TYPE,
      tlld_pkg::CODE_BAD_LEN, tlld_pkg::CODE_NONE, tlld_pkg::CODE_NONE,
      tlld_pkg::CODE_NO_TYPE, tlld_pkg::CODE_NO_TYPE, tlld_pkg::CODE_EARLY,
      tlld_pkg::CODE_BAD_LEN};
   logic [2:0] row_second [N_ROWS] = '{
      tlld_pkg::CODE_NONE, tlld_pkg::CODE_NONE, tlld_pkg::CODE_NONE, tlld_pkg::CODE_NONE,
      tlld_pkg::CODE_NONE, tlld_pkg::CODE_NONE, tlld_pkg::CODE_NONE, tlld_pkg::CODE_NONE,
      tlld_pkg::CODE_NONE, tlld_pkg::CODE_NONE, tlld_pkg::CODE_NONE, tlld_pkg::CODE_NONE,
      tlld_pkg::CODE_NONE, tlld_pkg::CODE_NONE, tlld_pkg::CODE_NO_LEN, tlld_pkg::CODE_NONE};
   int row_tail [N_ROWS] = '{0, 0, 0, 0, 0, 2, 0, 0, 0, 0, 0, 3, 0, 0, 0, 0};

   type_length_line_deframer #(
      .TYPE_BITS   (tlld_pkg::TYPE_BITS_DEF),
      .LENGTH_BITS (tlld_pkg::LENGTH_BITS_DEF)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_in_byte         (req_in_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_kind        (rsp_out_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_message_type    (rsp_message_type),
      .rsp_last_of_message (rsp_last_of_message),
      .rsp_status_code     (rsp_status_code)
   );

   always #2 clock = ~clock;

   function automatic deframed_type make_result(logic kind, logic [7:0] data,
                                                logic [31:0] mtype, logic last,
                                                logic [2:0] code);
      deframed_type r;
      r.kind  = kind;
      r.data  = data;
      r.mtype = mtype;
      r.last  = last;
      r.code  = code;
      return r;
   endfunction

   task report(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      errors++;
   endtask

   task clear_header;
      hist     = 32'h0;
      phase    = PH_SEEK;
      type_acc = 32'h0;
      len_acc  = 31'h0;
      type_bad = 1'b0;
      len_bad  = 1'b0;
      type_dig = 1'b0;
      len_dig  = 1'b0;
      early    = 1'b0;
      cr_held  = 1'b0;
      run      = 3'd0;
   endtask

   task automatic add_digit(inout logic [63:0] acc, inout logic has, inout logic bad,
                            input logic [7:0] c, input logic [63:0] limit);
      logic [63:0] d;
      if (c < tlld_pkg::CHAR_ZERO || c > tlld_pkg::CHAR_NINE) begin
         bad = 1'b1;
      end else begin
         d   = 64'(c - tlld_pkg::CHAR_ZERO);
         has = 1'b1;
         if (!bad) begin
            if (acc > (limit - d) / 64'd10)
               bad = 1'b1;
            else
               acc = acc * 64'd10 + d;
         end
      end
   endtask

   task feed_char(input logic [7:0] b);
      logic [31:0] w;
      logic [63:0] acc;
      logic        type_mark, len_mark;
      w         = hist;
      type_mark = (w == tlld_pkg::WORD_TYPE) && (b == tlld_pkg::CHAR_COLON);
      len_mark  = (w == tlld_pkg::WORD_LEN) && (b == tlld_pkg::CHAR_COLON);
      hist      = {w[23:0], b};
      if (type_mark) begin
         early    = (phase != PH_SEEK) || (run > 3'd4);
         phase    = PH_TYPE;
         type_acc = 32'h0;
         len_acc  = 31'h0;
         type_bad = 1'b0;
         len_bad  = 1'b0;
         type_dig = 1'b0;
         len_dig  = 1'b0;
         run      = 3'd0;
      end else begin
         if (phase == PH_TYPE && len_mark) begin
            phase = PH_LEN;
         end else if (phase == PH_TYPE) begin
            // type digits are read four bytes late, so ";Len" never reaches them
            if (run >= 3'd4) begin
               acc = {32'h0, type_acc};
               add_digit(acc, type_dig, type_bad, w[31:24], TYPE_MAX);
               type_acc = acc[31:0];
            end
         end else if (phase == PH_LEN) begin
            acc = {33'h0, len_acc};
            add_digit(acc, len_dig, len_bad, b, LEN_MAX);
            len_acc = acc[30:0];
         end
         if (run < 3'd7)
            run = run + 3'd1;
      end
   endtask

   task push_status(input logic [2:0] code);
      step_results.push_back(make_result(tlld_pkg::KIND_STATUS, 8'h00, 32'h0, 1'b0, code));
   endtask

   task close_line;
      if (phase == PH_SEEK) begin
         push_status(tlld_pkg::CODE_NO_TYPE);
      end else begin
         if (early)
            push_status(tlld_pkg::CODE_EARLY);
         if (phase == PH_TYPE) begin
            push_status(tlld_pkg::CODE_NO_LEN);
         end else if (type_bad || !type_dig) begin
            push_status(tlld_pkg::CODE_BAD_TYPE);
         end else if (len_bad || !len_dig) begin
            push_status(tlld_pkg::CODE_BAD_LEN);
         end else begin
            cur_type = type_acc;
            pay_left = len_acc;
            pay_mode = (len_acc != 31'h0);
         end
      end
      clear_header();
      line_closed = 1'b1;
   endtask

   task deframe_byte(input logic [7:0] b);
      step_results.delete();
      line_closed = 1'b0;
      if (pay_mode) begin
         pay_left = pay_left - 31'd1;
         step_results.push_back(make_result(tlld_pkg::KIND_PAYLOAD, b, cur_type,
                                            pay_left == 31'h0, tlld_pkg::CODE_NONE));
         if (pay_left == 31'h0)
            pay_mode = 1'b0;
      end else if (cr_held && b == tlld_pkg::CHAR_LF) begin
         cr_held = 1'b0;
         close_line();
      end else begin
         if (cr_held) begin
            cr_held = 1'b0;
            feed_char(tlld_pkg::CHAR_CR);
         end
         if (b == tlld_pkg::CHAR_CR)
            cr_held = 1'b1;
         else
            feed_char(b);
      end
   endtask

   // expectations are pushed before the result side is looked at; a result never
   // leaves in the cycle its byte is taken
   always @(posedge clock) begin : monitor
      deframed_type   got, want;
      typed_line_type tl;
      if (!reset) begin
         if (req_valid && req_ready) begin
            deframe_byte(req_in_byte);
            if (!req_typed) begin
               foreach (step_results[k])
                  pending_results.push_back(step_results[k]);
            end else if (line_closed) begin
               tl = typed_lines.pop_front();
               if (tl.count > 2'd0)
                  pending_results.push_back(make_result(tlld_pkg::KIND_STATUS, 8'h00,
                                                        32'h0, 1'b0, tl.first));
               if (tl.count > 2'd1)
                  pending_results.push_back(make_result(tlld_pkg::KIND_STATUS, 8'h00,
                                                        32'h0, 1'b0, tl.second));
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = make_result(rsp_out_kind, rsp_payload_byte, rsp_message_type,
                              rsp_last_of_message, rsp_status_code);
            if (pending_results.size() == 0) begin
               report($sformatf("unexpected transaction kind %0d byte %02h code %0d",
                                got.kind, got.data, got.code));
            end else begin
               want = pending_results.pop_front();
               if (got.kind !== want.kind)
                  report($sformatf("out_kind %0d, expected %0d", got.kind, want.kind));
               if (got.data !== want.data)
                  report($sformatf("payload_byte %02h, expected %02h", got.data, want.data));
               if (got.mtype !== want.mtype)
                  report($sformatf("message_type %0d, expected %0d", got.mtype, want.mtype));
               if (got.last !== want.last)
                  report($sformatf("last_of_message %0d, expected %0d", got.last, want.last));
               if (got.code !== want.code)
                  report($sformatf("status_code %0d, expected %0d", got.code, want.code));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_on && $urandom_range(0, 4) == 0)
            stall_left <= $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** type_length_line_deframer: FAILED **");
         $finish;
      end
   end

   task send_byte(input logic [7:0] b, input logic typed);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_typed   <= typed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task send_frame(input logic typed);
      foreach (frame_q[k])
         send_byte(frame_q[k], typed);
      frame_q.delete();
   endtask

   task append_text(input string s);
      for (int k = 0; k < s.len(); k++)
         frame_q.push_back(s[k]);
   endtask

   // hold the sender until every outstanding result has been seen
   task drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] non_digit();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while ((c >= tlld_pkg::CHAR_ZERO && c <= tlld_pkg::CHAR_NINE)
             || c == tlld_pkg::CHAR_CR || c == tlld_pkg::CHAR_LF);
      return c;
   endfunction

   function automatic string type_number();
      unique case ($urandom_range(0, 9))
         6:       return $sformatf("%0d", $urandom & 32'h7FFF_FFFF);
         7:       return "2147483647";
         8:       return $sformatf("000%0d", $urandom_range(0, 99));
         9:       return "0";
         default: return $sformatf("%0d", $urandom_range(0, 99));
      endcase
   endfunction

   function automatic string overflow_number();
      unique case ($urandom_range(0, 2))
         0:       return "2147483648";
         1:       return "4294967296";
         default: return "99999999999";
      endcase
   endfunction

   task build_message(output int pay_n);
      flaw_type flaw;
      string    ty, ln;
      int       k;
      pay_n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
      ty    = type_number();
      ln    = ($urandom_range(0, 7) == 0) ? $sformatf("00%0d", pay_n) : $sformatf("%0d", pay_n);
      if ($urandom_range(0, 99) < 85) begin
         append_text({"Type:", ty, ";Len:", ln, "\r\n"});
      end else begin
         flaw = flaw_type'($urandom_range(0, 7));
         unique case (flaw)
            FLAW_NOISE: begin
               k = $urandom_range(0, 24);
               repeat (k) frame_q.push_back(8'($urandom_range(0, 255)));
               append_text("\r\n");
               pay_n = 0;
            end
            FLAW_PREFIX: begin
               k = $urandom_range(1, 8);
               repeat (k) frame_q.push_back(non_digit());
               append_text({"Type:", ty, ";Len:", ln, "\r\n"});
            end
            FLAW_NO_LEN: begin
               append_text($urandom_range(0, 1) ? {"Type:", ty, "\r\n"}
                                                : {"Type:", ty, ";Lem:", ln, "\r\n"});
               pay_n = 0;
            end
            FLAW_TYPE_CHAR: begin
               append_text({"Type:", ty});
               frame_q.push_back(non_digit());
               append_text({";Len:", ln, "\r\n"});
               pay_n = 0;
            end
            FLAW_LEN_CHAR: begin
               append_text({"Type:", ty, ";Len:"});
               if ($urandom_range(0, 3) != 0) begin
                  if ($urandom_range(0, 1)) frame_q.push_back(non_digit());
                  append_text(ln);
                  frame_q.push_back(non_digit());
               end
               append_text("\r\n");
               pay_n = 0;
            end
            FLAW_OVERFLOW: begin
               append_text($urandom_range(0, 1)
                           ? {"Type:", overflow_number(), ";Len:", ln, "\r\n"}
                           : {"Type:", ty, ";Len:", overflow_number(), "\r\n"});
               pay_n = 0;
            end
            FLAW_REMARK: begin
               // a second marker restarts the header, from type or length text
               append_text($urandom_range(0, 1) ? {"Type:", type_number()}
                                                : {"Type:", type_number(), ";Len:9"});
               append_text({"Type:", ty, ";Len:", ln, "\r\n"});
            end
            default: begin
               append_text($urandom_range(0, 1) ? "\rA\n" : "\n\r");
               append_text({"Type:", ty, ";Len:", ln, "\r\n"});
            end
         endcase
      end
   endtask

   initial begin : stimulus
      typed_line_type tl;
      int             pay_n, start, next_phase;
      logic           paused;
      pay_mode = 1'b0;
      pay_left = 31'h0;
      cur_type = 32'h0;
      clear_header();
      line_closed = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_ROWS; r++) begin
         if (row_reports[r] >= 0) begin
            tl.count  = 2'(row_reports[r]);
            tl.first  = row_first[r];
            tl.second = row_second[r];
            typed_lines.push_back(tl);
         end
         append_text(row_text[r]);
         send_frame(row_reports[r] >= 0);
         for (int k = 0; k < row_tail[r]; k++)
            send_byte((k % 2) ? 8'hFF : 8'h00, 1'b0);
      end
      drain();

      start      = bytes_sent;
      next_phase = 0;
      paused     = 1'b0;
      while (bytes_sent - start < RANDOM_ITEMS) begin
         if (bytes_sent - start >= next_phase) begin
            idle_on    = (bytes_sent - start < RANDOM_ITEMS - QUIET_ITEMS)
                         && ($urandom_range(0, 3) != 0);
            next_phase = next_phase + 150;
         end
         if (!paused && bytes_sent - start >= RANDOM_ITEMS / 2) begin
            drain();
            paused = 1'b1;
         end
         build_message(pay_n);
         send_frame(1'b0);
         repeat (pay_n) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end

      drain();
      repeat (16) @(posedge clock);
      if (errors == 0)
         $display("** type_length_line_deframer: PASSED **");
      else
         $display("** type_length_line_deframer: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tlld_pkg.sv
rtl/tlld_header.sv
rtl/type_length_line_deframer.sv
test/tb_type_length_line_deframer.sv
